@@ rtl/core/tacpu_pkg.sv @@
// types and constants shared by the tiny accumulator cpu execute block
`timescale 1ns / 1ps
`default_nettype none

package tacpu_pkg;

  localparam int unsigned DataBits  = 8;
  localparam int unsigned ShiftBits = $clog2(DataBits);

  // request kind carried in the op field
  localparam logic ItemLoad = 1'b0;
  localparam logic ItemExec = 1'b1;

  typedef enum logic [3:0] {
    OpcNop    = 4'd0,
    OpcAdd    = 4'd1,
    OpcAnd    = 4'd2,
    OpcSra    = 4'd3,
    OpcSll    = 4'd4,
    OpcLdr    = 4'd5,
    OpcStr    = 4'd6,
    OpcJmp    = 4'd7,
    OpcBez    = 4'd8,
    OpcBlt    = 4'd9,
    OpcNopAlt = 4'd10,
    OpcClr    = 4'd11,
    OpcNot    = 4'd12,
    OpcInc    = 4'd13,
    OpcDmp    = 4'd14,
    OpcHlt    = 4'd15
  } opcode_e;

  typedef enum logic [2:0] {
    ModeR0     = 3'd0,
    ModeR1     = 3'd1,
    ModeDispR0 = 3'd2,
    ModeDispR1 = 3'd3,
    ModeImm    = 3'd4,
    ModeAbs    = 3'd5,
    ModePcRel  = 3'd6,
    ModeRsvd   = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    StsExecuted  = 3'd0,
    StsLoaded    = 3'd1,
    StsHaltInstr = 3'd2,
    StsInvalid   = 3'd3,
    StsUnknown   = 3'd4,
    StsHaltIdle  = 3'd5,
    StsDump      = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmInstr,
    FsmImm,
    FsmOper,
    FsmExec
  } state_e;

  typedef struct packed {
    logic                op;
    logic [7:0]          mem_addr;
    logic [DataBits-1:0] mem_data;
  } in_req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [7:0]          instr_pc;
    logic [DataBits-1:0] instr_byte;
    logic [DataBits-1:0] imm_value;
    logic                imm_valid;
    logic [DataBits-1:0] reg0;
    logic [DataBits-1:0] reg1;
    logic                branch_taken;
    logic                store_valid;
    logic [7:0]          store_addr;
    logic [DataBits-1:0] store_data;
  } out_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/tiny_accumulator_cpu_execute.sv @@
// top level: two-register accumulator cpu executing one request at a time
//
//   channel | direction | handshake                      | payload
//   in      | input     | in_valid_i / in_stall_o        | in_req_i  (tacpu_pkg::in_req_t)
//   out     | output    | out_valid_o / out_stall_i      | out_rsp_o (tacpu_pkg::out_rsp_t)
//
// states per request: a load, or any request on a halted cpu, goes from idle to exec;
// an instruction goes instr, imm if it has an immediate, oper for a memory operand, exec.
// all of it is set by the single ram port: instruction, immediate and operand
// are read one after another, each through the registered read.
// reset clears pc, r0, r1, halted and the result valid flag; memory is undefined
// until loaded and gets no clearing pass.
// in_stall_o is low only while idle; a finished result waits in the result
// register while the next request is taken, and a full result register holds
// the execute step until it drains.
`timescale 1ns / 1ps
`default_nettype none

module tiny_accumulator_cpu_execute #(
  parameter int unsigned ADDR_WIDTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tacpu_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tacpu_pkg::out_rsp_t out_rsp_o
);

  import tacpu_pkg::*;

  localparam int unsigned MemDepth = 1 << ADDR_WIDTH;

  typedef logic [ADDR_WIDTH-1:0] addr_t;
  typedef logic [DataBits-1:0]   data_t;

  state_e   state_q, state_d;
  addr_t    pc_q, pc_d;
  data_t    r0_q, r0_d;
  data_t    r1_q, r1_d;
  logic     halted_q, halted_d;
  data_t    instr_q, instr_d;
  data_t    imm_q, imm_d;
  logic     imm_v_q, imm_v_d;
  data_t    opd_q, opd_d;
  addr_t    ea_q, ea_d;
  addr_t    ipc_q, ipc_d;
  status_e  status_q, status_d;
  logic     out_valid_q, out_valid_d;
  out_rsp_t out_q, out_d;

  logic  ram_we;
  addr_t ram_addr;
  data_t ram_wdata;
  data_t ram_rdata;

  logic    accept;
  logic    out_free;
  logic    commit;
  opcode_e f_opc;
  mode_e   f_mode;
  logic    f_invalid;
  logic    f_unknown;
  logic    f_need_imm;
  opcode_e i_opc;
  mode_e   i_mode;
  logic    i_sel;
  logic    need_opd;
  addr_t   ea_calc;

  data_t    ra;
  data_t    val;
  data_t    ra_new;
  logic     br;
  logic     st;
  logic     hlt;
  status_e  rsp_status;
  out_rsp_t rsp;

  tacpu_ram #(
    .Width(DataBits),
    .Depth(MemDepth)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign commit   = (state_q == FsmExec) && out_free;

  // decode of the fresh instruction byte and of the latched one
  always_comb begin
    f_opc      = opcode_e'(ram_rdata[7:4]);
    f_mode     = mode_e'(ram_rdata[3:1]);
    f_invalid  = (f_opc >= OpcLdr) && (f_opc <= OpcNopAlt) &&
                 (f_mode == ModeR0 || f_mode == ModeR1 || f_mode == ModeImm);
    f_unknown  = (f_opc >= OpcAdd) && (f_opc <= OpcBlt) && (f_mode == ModeRsvd);
    f_need_imm = (f_opc >= OpcAdd) && (f_opc <= OpcBlt) &&
                 (f_mode != ModeR0) && (f_mode != ModeR1);
    i_opc      = opcode_e'(instr_q[7:4]);
    i_mode     = mode_e'(instr_q[3:1]);
    i_sel      = instr_q[0];
    need_opd   = (i_opc >= OpcAdd) && (i_opc <= OpcLdr) && (i_mode != ModeImm);
    unique case (i_mode)
      ModeDispR0: ea_calc = ADDR_WIDTH'(r0_q + ram_rdata);
      ModeDispR1: ea_calc = ADDR_WIDTH'(r1_q + ram_rdata);
      ModeAbs:    ea_calc = ADDR_WIDTH'(ram_rdata);
      ModePcRel:  ea_calc = pc_q + ADDR_WIDTH'(ram_rdata);
      default:    ea_calc = '0;
    endcase
  end

  // execute step, evaluated from latched operands
  always_comb begin
    ra = i_sel ? r1_q : r0_q;
    unique case (i_mode)
      ModeR0:  val = r0_q;
      ModeR1:  val = r1_q;
      ModeImm: val = imm_q;
      default: val = opd_q;
    endcase
    ra_new     = ra;
    br         = 1'b0;
    st         = 1'b0;
    hlt        = 1'b0;
    rsp_status = status_q;
    if (status_q == StsExecuted) begin
      unique case (i_opc)
        OpcAdd: ra_new = ra + val;
        OpcAnd: ra_new = ra & val;
        OpcSra: begin
          if (val >= DataBits'(DataBits)) begin
            ra_new = {DataBits{ra[DataBits-1]}};
          end else begin
            ra_new = $signed(ra) >>> val[ShiftBits-1:0];
          end
        end
        OpcSll: begin
          if (val >= DataBits'(DataBits)) begin
            ra_new = '0;
          end else begin
            ra_new = ra << val[ShiftBits-1:0];
          end
        end
        OpcLdr:    ra_new = opd_q;
        OpcStr:    st = 1'b1;
        OpcJmp:    br = 1'b1;
        OpcBez:    br = (ra == '0);
        OpcBlt:    br = ra[DataBits-1];
        OpcClr:    ra_new = '0;
        OpcNot:    ra_new = ~ra;
        OpcInc:    ra_new = ra + 1'b1;
        OpcDmp:    rsp_status = StsDump;
        OpcHlt: begin
          rsp_status = StsHaltInstr;
          hlt        = 1'b1;
        end
        OpcNop, OpcNopAlt: ra_new = ra;
      endcase
    end
    rsp.status       = rsp_status;
    rsp.instr_pc     = 8'(ipc_q);
    rsp.instr_byte   = instr_q;
    rsp.imm_value    = imm_q;
    rsp.imm_valid    = imm_v_q;
    rsp.reg0         = (status_q == StsExecuted && !i_sel) ? ra_new : r0_q;
    rsp.reg1         = (status_q == StsExecuted && i_sel) ? ra_new : r1_q;
    rsp.branch_taken = br;
    rsp.store_valid  = st;
    rsp.store_addr   = st ? 8'(ea_q) : 8'd0;
    rsp.store_data   = st ? ra : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FsmIdle: begin
        if (accept) begin
          if (in_req_i.op == ItemExec && !halted_q) begin
            state_d = FsmInstr;
          end else begin
            state_d = FsmExec;
          end
        end
      end
      FsmInstr: begin
        if (f_invalid || f_unknown || !f_need_imm) begin
          state_d = FsmExec;
        end else begin
          state_d = FsmImm;
        end
      end
      FsmImm:  state_d = need_opd ? FsmOper : FsmExec;
      FsmOper: state_d = FsmExec;
      FsmExec: begin
        if (commit) begin
          state_d = FsmIdle;
        end
      end
      default: state_d = FsmIdle;
    endcase
  end

  // datapath and memory control
  always_comb begin
    in_stall_o  = 1'b1;
    ram_we      = 1'b0;
    ram_addr    = pc_q;
    ram_wdata   = ra;
    pc_d        = pc_q;
    r0_d        = r0_q;
    r1_d        = r1_q;
    halted_d    = halted_q;
    instr_d     = instr_q;
    imm_d       = imm_q;
    imm_v_d     = imm_v_q;
    opd_d       = opd_q;
    ea_d        = ea_q;
    ipc_d       = ipc_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      FsmIdle: begin
        in_stall_o = 1'b0;
        if (accept) begin
          instr_d = '0;
          imm_d   = '0;
          imm_v_d = 1'b0;
          if (in_req_i.op == ItemLoad) begin
            ram_we    = 1'b1;
            ram_addr  = ADDR_WIDTH'(in_req_i.mem_addr);
            ram_wdata = in_req_i.mem_data;
            status_d  = StsLoaded;
            ipc_d     = '0;
          end else if (halted_q) begin
            status_d = StsHaltIdle;
            ipc_d    = pc_q;
          end else begin
            status_d = StsExecuted;
            ipc_d    = pc_q;
            pc_d     = pc_q + 1'b1;
          end
        end
      end
      FsmInstr: begin
        instr_d = ram_rdata;
        if (f_invalid) begin
          halted_d = 1'b1;
          status_d = StsInvalid;
        end else if (f_unknown) begin
          halted_d = 1'b1;
          status_d = StsUnknown;
        end else if (f_need_imm) begin
          pc_d = pc_q + 1'b1;
        end
      end
      FsmImm: begin
        imm_d    = ram_rdata;
        imm_v_d  = 1'b1;
        ea_d     = ea_calc;
        ram_addr = ea_calc;
      end
      FsmOper: opd_d = ram_rdata;
      FsmExec: begin
        ram_addr = ea_q;
        if (commit) begin
          out_d       = rsp;
          out_valid_d = 1'b1;
          r0_d        = rsp.reg0;
          r1_d        = rsp.reg1;
          ram_we      = st;
          if (br) begin
            pc_d = ea_q;
          end
          if (hlt) begin
            halted_d = 1'b1;
          end
        end
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsmIdle;
      pc_q        <= '0;
      r0_q        <= '0;
      r1_q        <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      r0_q        <= r0_d;
      r1_q        <= r1_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    instr_q  <= instr_d;
    imm_q    <= imm_d;
    imm_v_q  <= imm_v_d;
    opd_q    <= opd_d;
    ea_q     <= ea_d;
    ipc_q    <= ipc_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // a halted cpu never resumes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted flag cleared");

  // memory is written only by a load request or by a committing store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == FsmIdle && accept) || commit))
    else $error("unexpected memory write");

  // an execute request on a halted cpu goes straight to the report step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_req_i.op == ItemExec && halted_q) |=>
      (state_q == FsmExec && status_q == StsHaltIdle))
    else $error("halted request not reported");

  // a store or branch is only reported by an executed instruction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.store_valid || out_rsp_o.branch_taken)) |->
      (out_rsp_o.status == StsExecuted))
    else $error("store or branch on a non-executed request");

endmodule

`default_nettype wire

@@ rtl/core/tacpu_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module tacpu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
